// ----- rtl/ebsd_pkg.sv -----
// Shared types and constants for the straight-drive wheel balancer.
// No dependencies; imported by every module of the block.
package ebsd_pkg;

    // Field widths
    localparam int SPEED_W  = 10;
    localparam int GAIN_W   = 8;
    localparam int TARGET_W = 16;
    localparam int TICK_W   = 17;
    localparam int ENC_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [SPEED_W-1:0] SPEED_MAX  = 10'd1023;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd10;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request kinds
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b1;

    // Which wheel trails the other
    typedef enum logic [1:0] {
        LAG_NONE  = 2'b00,
        LAG_LEFT  = 2'b01,
        LAG_RIGHT = 2'b10
    } t_lag;

    // One job handed from the front to the back
    typedef struct packed {
        logic              done;
        t_lag              lag;
        logic [TICK_W-1:0] deficit;
    } t_job;

    // Front status seen by the top level
    typedef struct packed {
        logic running;
        logic push;
    } t_front_stat;

endpackage

// ----- rtl/encoder_balanced_straight_drive.sv -----
// Top level of the straight-drive wheel balancer: config registers,
// front end, job queue and divide back end. Depends on ebsd_pkg and submodules.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_req_type, i_target_tics, i_encoder_bits
//   result    out        o_valid / i_ready  o_left_speed, o_right_speed, o_done_res
//   config    in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// The front takes one request per cycle while the queue has room.
// A sample with a trailing wheel passes the back end through pop, a 17-step divide
// of the 17-bit deficit, add/saturate and output load; other samples skip the
// divide and the add. Start requests and ignored samples produce no result.
// Reset is synchronous, active low; a stalled result holds in the output
// register while the back end continues with the next queued job and waits in S_OUT.
module encoder_balanced_straight_drive #(
    parameter int QUEUE_DEPTH = ebsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [ebsd_pkg::TARGET_W-1:0]   i_target_tics,
    input  logic [ebsd_pkg::ENC_W-1:0]      i_encoder_bits,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ebsd_pkg::SPEED_W-1:0]    o_left_speed,
    output logic [ebsd_pkg::SPEED_W-1:0]    o_right_speed,
    output logic                            o_done_res,
    input  logic                            i_cfg_wr_en,
    input  logic [ebsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ebsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ebsd_pkg::*;

    logic [SPEED_W-1:0] r_min_speed;
    logic [GAIN_W-1:0]  r_gain;
    t_job               front_job, queue_job;
    t_front_stat        front_stat;
    logic               q_full, q_valid, q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= '0;
            r_gain      <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MIN_SPEED: r_min_speed <= i_cfg_data[SPEED_W-1:0];
                REG_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    ebsd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_target_tics  (i_target_tics),
        .i_encoder_bits (i_encoder_bits),
        .i_q_full       (q_full),
        .o_job          (front_job),
        .o_stat         (front_stat)
    );

    ebsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_stat.push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (queue_job)
    );

    ebsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (queue_job),
        .o_pop          (q_pop),
        .i_min_speed    (r_min_speed),
        .i_gain_divisor (r_gain),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_speed   (o_left_speed),
        .o_right_speed  (o_right_speed),
        .o_done_res     (o_done_res)
    );

`ifndef SYNTHESIS
    // No push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(front_stat.push && q_full))
        else $error("job pushed into full queue");

    // The back end only pops a queued job
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // A finishing result carries zero speeds
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_left_speed == '0 && o_right_speed == '0))
        else $error("done result with nonzero speed");

    // An accepted start request begins a run
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_START) |=> front_stat.running)
        else $error("start request did not begin a run");
`endif

endmodule

// ----- rtl/ebsd_front.sv -----
// Front end: accepts requests, tracks encoder ticks and classifies each sample.
// Depends on ebsd_pkg; pushes jobs into ebsd_queue.
module ebsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [ebsd_pkg::TARGET_W-1:0] i_target_tics,
    input  logic [ebsd_pkg::ENC_W-1:0]    i_encoder_bits,
    input  logic                          i_q_full,
    output ebsd_pkg::t_job                o_job,
    output ebsd_pkg::t_front_stat         o_stat
);
    import ebsd_pkg::*;

    logic [ENC_W-1:0]    r_prev,    n_prev;
    logic [TICK_W-1:0]   r_left,    n_left;
    logic [TICK_W-1:0]   r_right,   n_right;
    logic [TARGET_W-1:0] r_target,  n_target;
    logic                r_running, n_running;

    logic                accept;
    logic                push;
    logic [ENC_W-1:0]    changed;
    logic [TICK_W-1:0]   left_nx, right_nx, target_ext;
    logic                finish;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Tick update and classification of one sample
    always_comb begin
        changed    = i_encoder_bits ^ r_prev;
        left_nx    = r_left  + TICK_W'(|changed[1:0]);
        right_nx   = r_right + TICK_W'(|changed[3:2]);
        target_ext = {1'b0, r_target};
        finish     = (left_nx > target_ext) || (right_nx > target_ext);

        o_job.done    = finish;
        o_job.lag     = LAG_NONE;
        o_job.deficit = '0;
        if (!finish && left_nx < right_nx) begin
            o_job.lag     = LAG_LEFT;
            o_job.deficit = right_nx - left_nx;
        end else if (!finish && right_nx < left_nx) begin
            o_job.lag     = LAG_RIGHT;
            o_job.deficit = left_nx - right_nx;
        end

        push = accept && (i_req_type == REQ_SAMPLE) && r_running;
    end

    // Next state
    always_comb begin
        n_prev    = r_prev;
        n_left    = r_left;
        n_right   = r_right;
        n_target  = r_target;
        n_running = r_running;
        if (accept && i_req_type == REQ_START) begin
            n_prev    = i_encoder_bits;
            n_left    = '0;
            n_right   = '0;
            n_target  = i_target_tics;
            n_running = 1'b1;
        end else if (push) begin
            n_prev  = i_encoder_bits;
            n_left  = left_nx;
            n_right = right_nx;
            if (finish) begin
                n_running = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_target  <= '0;
            r_running <= 1'b0;
        end else begin
            r_prev    <= n_prev;
            r_left    <= n_left;
            r_right   <= n_right;
            r_target  <= n_target;
            r_running <= n_running;
        end
    end

    assign o_stat.running = r_running;
    assign o_stat.push    = push;

endmodule

// ----- rtl/ebsd_queue.sv -----
// Small job queue between the front and the back.
// Depends on ebsd_pkg for the job type.
module ebsd_queue #(
    parameter int DEPTH = ebsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ebsd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output ebsd_pkg::t_job o_job
);
    import ebsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/ebsd_back.sv -----
// Back end: divides the tick deficit by the gain, forms the speeds and
// holds the result in an output register. Depends on ebsd_pkg.
module ebsd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  ebsd_pkg::t_job               i_job,
    output logic                         o_pop,
    input  logic [ebsd_pkg::SPEED_W-1:0] i_min_speed,
    input  logic [ebsd_pkg::GAIN_W-1:0]  i_gain_divisor,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ebsd_pkg::SPEED_W-1:0] o_left_speed,
    output logic [ebsd_pkg::SPEED_W-1:0] o_right_speed,
    output logic                         o_done_res
);
    import ebsd_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);
    localparam int SUM_W = TICK_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SUM  = 4'b0100,
        S_OUT  = 4'b1000
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [TICK_W-1:0]   r_quo,   n_quo;
    logic [GAIN_W-1:0]   r_rem,   n_rem;
    logic [GAIN_W-1:0]   r_div,   n_div;
    t_lag                r_lag,   n_lag;
    logic [SPEED_W-1:0]  r_res_left,  n_res_left;
    logic [SPEED_W-1:0]  r_res_right, n_res_right;
    logic                r_res_done,  n_res_done;
    logic                r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]  r_out_left, r_out_right;
    logic                r_out_done;
    logic                load_out;

    logic [GAIN_W:0]     trial, diff;
    logic                ge;
    logic [SUM_W-1:0]    sum;
    logic [SPEED_W-1:0]  corr_speed;

    // One restoring divide step
    always_comb begin
        trial = {r_rem, r_quo[TICK_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // Saturating add of the quotient to the base speed
    always_comb begin
        sum = {1'b0, r_quo} + SUM_W'(i_min_speed);
        corr_speed = (sum > SUM_W'(SPEED_MAX)) ? SPEED_MAX : sum[SPEED_W-1:0];
    end

    assign o_pop    = (r_state == S_IDLE) && i_job_valid;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_lag       = r_lag;
        n_res_left  = r_res_left;
        n_res_right = r_res_right;
        n_res_done  = r_res_done;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_lag       = i_job.lag;
                    n_res_left  = i_min_speed;
                    n_res_right = i_min_speed;
                    n_res_done  = 1'b0;
                    if (i_job.done) begin
                        n_res_left  = '0;
                        n_res_right = '0;
                        n_res_done  = 1'b1;
                        n_state     = S_OUT;
                    end else if (i_job.lag == LAG_NONE) begin
                        n_state = S_OUT;
                    end else begin
                        n_quo   = i_job.deficit;
                        n_rem   = '0;
                        // a zero divisor acts as one
                        n_div   = (i_gain_divisor == '0) ? GAIN_W'(1) : i_gain_divisor;
                        n_cnt   = CNT_W'(TICK_W - 1);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
                n_quo = {r_quo[TICK_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_lag == LAG_LEFT) begin
                    n_res_left = corr_speed;
                end else begin
                    n_res_right = corr_speed;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_lag       <= n_lag;
        r_res_left  <= n_res_left;
        r_res_right <= n_res_right;
        r_res_done  <= n_res_done;
        if (load_out) begin
            r_out_left  <= r_res_left;
            r_out_right <= r_res_right;
            r_out_done  <= r_res_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_speed  = r_out_left;
    assign o_right_speed = r_out_right;
    assign o_done_res    = r_out_done;

endmodule
